### rtl/tohp_pkg.sv
// Shared types, sizes and helper functions for the clock-offset histogram block.
// No dependencies. The front end, the command queue and the back end import it.
package tohp_pkg;

    localparam int NUM_SERVERS       = 8;
    localparam int GROUPS_PER_SERVER = 14;
    localparam int HIST_BINS         = 128;
    localparam int COUNT_WIDTH       = 32;

    localparam int SERVER_W = 3;
    localparam int GROUP_W  = 4;
    localparam int CLOCK_W  = 7;
    localparam int BIN_W    = 7;
    localparam int PEAK_W   = 32;
    localparam int ACTION_W = 2;

    localparam int NUM_ROWS = NUM_SERVERS * GROUPS_PER_SERVER;
    localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int ADDR_W   = ROW_W + BIN_W;
    localparam int DEPTH    = NUM_ROWS * HIST_BINS;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Action codes of the input item
    localparam logic [ACTION_W-1:0] ACT_HIT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        CMD_HIT,
        CMD_QUERY,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                grp_ok;
        logic [ROW_W-1:0]    row;
        logic [BIN_W-1:0]    bin;
        logic [SERVER_W-1:0] server;
        logic [GROUP_W-1:0]  group;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_SCAN,
        ST_EMIT
    } back_state_t;

    function automatic logic group_ok(input logic [SERVER_W-1:0] server,
                                      input logic [GROUP_W-1:0] group);
        return (int'(server) < NUM_SERVERS) && (int'(group) < GROUPS_PER_SERVER);
    endfunction

    function automatic logic [ROW_W-1:0] row_index(input logic [SERVER_W-1:0] server,
                                                   input logic [GROUP_W-1:0] group);
        int r;
        r = int'(server) * GROUPS_PER_SERVER + int'(group);
        return ROW_W'(r);
    endfunction

    // Saturating increment
    function automatic count_t sat_inc(input count_t c);
        return (c == '1) ? c : c + COUNT_WIDTH'(1);
    endfunction

    // Clip a count to the 32-bit result field
    function automatic logic [PEAK_W-1:0] peak_clip(input count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        return (wide > 64'h0000_0000_FFFF_FFFF) ? '1 : wide[PEAK_W-1:0];
    endfunction

endpackage

### rtl/tohp_front.sv
// Front end: accepts items, classifies them and pushes commands into the queue.
// Depends on tohp_pkg.
module tohp_front
    import tohp_pkg::*;
(
    input  logic                hit_valid,
    output logic                hit_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [SERVER_W-1:0] server,
    input  logic [GROUP_W-1:0]  group,
    input  logic [CLOCK_W-1:0]  event_clock_low,
    input  logic [CLOCK_W-1:0]  chip_clock,
    input  q_stat_t             qstat,
    input  logic                clearing,
    output logic                push,
    output cmd_t                push_cmd
);

    logic keep;

    assign hit_stall = qstat.full || clearing;

    always_comb
    begin
        push_cmd.kind   = CMD_HIT;
        push_cmd.grp_ok = group_ok(server, group);
        push_cmd.row    = row_index(server, group);
        push_cmd.bin    = BIN_W'(event_clock_low - chip_clock);
        push_cmd.server = server;
        push_cmd.group  = group;
        keep            = 1'b0;
        case (action)
            ACT_HIT:
            begin
                // drop hits on groups that do not exist
                push_cmd.kind = CMD_HIT;
                keep          = push_cmd.grp_ok;
            end
            ACT_QUERY:
            begin
                push_cmd.kind = CMD_QUERY;
                keep          = 1'b1;
            end
            ACT_CLEAR:
            begin
                push_cmd.kind = CMD_CLEAR;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = hit_valid && !hit_stall && keep;

endmodule

### rtl/tohp_fifo.sv
// Short command queue between the front end and the back end.
// Depends on tohp_pkg.
module tohp_fifo
    import tohp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t qstat
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full && !pop))
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### rtl/tohp_back.sv
// Back end: bin memory with read-modify-write and bypass, peak scan, clearing
// pass and the result register. Depends on tohp_pkg.
module tohp_back
    import tohp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                head,
    input  q_stat_t             qstat,
    output logic                pop,
    output logic                clearing,
    output logic                peak_valid,
    input  logic                peak_stall,
    output logic [SERVER_W-1:0] out_server,
    output logic [GROUP_W-1:0]  out_group,
    output logic [BIN_W-1:0]    peak_bin,
    output logic [PEAK_W-1:0]   peak_count
);

    back_state_t state_reg;
    back_state_t state_next;

    count_t mem [DEPTH];

    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   clr_addr_next;
    logic [BIN_W-1:0]    scan_bin_reg;
    logic                scan_issued_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SERVER_W-1:0] srv_reg;
    logic [GROUP_W-1:0]  grp_reg;
    count_t              best_reg;
    logic [BIN_W-1:0]    best_bin_reg;

    logic                rd_valid_reg;
    logic                rd_scan_reg;
    logic                rd_last_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    count_t              rdata_reg;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    count_t              fwd_data_reg;

    logic                peak_valid_reg;
    logic [SERVER_W-1:0] out_server_reg;
    logic [GROUP_W-1:0]  out_group_reg;
    logic [BIN_W-1:0]    peak_bin_reg;
    logic [PEAK_W-1:0]   peak_count_reg;

    logic                rd_en;
    logic                rd_scan;
    logic                rd_last;
    logic [ADDR_W-1:0]   rd_addr;
    logic                we;
    logic [ADDR_W-1:0]   wa;
    count_t              wd;
    logic                load_query;
    logic                out_load;
    count_t              rd_eff;

    // bypass the write of the previous cycle
    assign rd_eff = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                      : rdata_reg;
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!qstat.empty)
                begin
                    if (head.kind == CMD_QUERY)
                    begin
                        state_next = head.grp_ok ? ST_SCAN : ST_EMIT;
                    end
                    else if (head.kind == CMD_CLEAR && !rd_valid_reg)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_valid_reg && rd_scan_reg && rd_last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!peak_valid_reg || !peak_stall)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        rd_en         = 1'b0;
        rd_scan       = 1'b0;
        rd_last       = 1'b0;
        rd_addr       = rd_addr_reg;
        we            = 1'b0;
        wa            = rd_addr_reg;
        wd            = sat_inc(rd_eff);
        clr_addr_next = clr_addr_reg;
        load_query    = 1'b0;
        out_load      = 1'b0;

        // finish the hit read issued in the previous cycle
        if (rd_valid_reg && !rd_scan_reg)
        begin
            we = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we            = 1'b1;
                wa            = clr_addr_reg;
                wd            = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_RUN:
            begin
                if (!qstat.empty)
                begin
                    case (head.kind)
                        CMD_HIT:
                        begin
                            pop     = 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = {head.row, head.bin};
                        end
                        CMD_QUERY:
                        begin
                            pop        = 1'b1;
                            load_query = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            // hold until the pending hit has written back
                            if (!rd_valid_reg)
                            begin
                                pop           = 1'b1;
                                clr_addr_next = '0;
                            end
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!scan_issued_reg)
                begin
                    rd_en   = 1'b1;
                    rd_scan = 1'b1;
                    rd_addr = {row_reg, scan_bin_reg};
                    rd_last = (scan_bin_reg == BIN_W'(HIST_BINS - 1));
                end
            end
            ST_EMIT:
            begin
                out_load = !peak_valid_reg || !peak_stall;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            scan_issued_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            peak_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_valid_reg  <= rd_en;
            fwd_valid_reg <= we;
            if (load_query)
            begin
                scan_issued_reg <= 1'b0;
            end
            else if (rd_last)
            begin
                scan_issued_reg <= 1'b1;
            end
            if (out_load)
            begin
                peak_valid_reg <= 1'b1;
            end
            else if (!peak_stall)
            begin
                peak_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_scan_reg  <= rd_scan;
        rd_last_reg  <= rd_last;
        fwd_addr_reg <= wa;
        fwd_data_reg <= wd;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (load_query)
        begin
            row_reg      <= head.row;
            srv_reg      <= head.server;
            grp_reg      <= head.group;
            best_reg     <= '0;
            best_bin_reg <= '0;
            scan_bin_reg <= '0;
        end
        else
        begin
            if (rd_scan)
            begin
                scan_bin_reg <= scan_bin_reg + BIN_W'(1);
            end
            // strict compare keeps the lowest bin on ties
            if (rd_valid_reg && rd_scan_reg && (rd_eff > best_reg))
            begin
                best_reg     <= rd_eff;
                best_bin_reg <= rd_addr_reg[BIN_W-1:0];
            end
        end
        if (out_load)
        begin
            out_server_reg <= srv_reg;
            out_group_reg  <= grp_reg;
            peak_bin_reg   <= best_bin_reg;
            peak_count_reg <= peak_clip(best_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign peak_valid = peak_valid_reg;
    assign out_server = out_server_reg;
    assign out_group  = out_group_reg;
    assign peak_bin   = peak_bin_reg;
    assign peak_count = peak_count_reg;

`ifndef ASSERT_OFF
    a_clear_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !rd_valid_reg)
        else $error("hit write pending during clearing pass");

    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && rd_scan_reg) |-> (state_reg == ST_SCAN))
        else $error("scan data returned outside scan");

    a_hit_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && !rd_scan_reg) |-> ($past(state_reg) == ST_RUN))
        else $error("hit read issued outside run");
`endif

endmodule

### rtl/timing_offset_histogram_peak.sv
// Top level of the clock-offset histogram with peak finder.
// Depends on tohp_pkg, tohp_front, tohp_fifo and tohp_back.
//
// Each hit item adds one to bin (event_clock_low - chip_clock) mod 128 of
// its group's histogram, held in a single-port-write, single-port-read
// memory of NUM_SERVERS * GROUPS_PER_SERVER * 128 saturating counters.
// Hits sustain one item per cycle while hit_stall is low: the read-modify-write
// of a bin reads the counter into a register and then writes the incremented
// value back; a one-entry bypass of the last write covers back-to-back hits on
// the same bin. A query walks the group's 128 bins through the memory read port,
// so it occupies the back end until its result is loaded into the output
// register; items keep entering the four-entry command queue meanwhile, and
// hit_stall rises once it is full. After reset and after every clear item the
// back end sweeps the memory once, one entry per cycle (14336 entries at the
// default sizes), with hit_stall held high throughout. Hits on a nonexistent
// server or group and action code 3 are taken and dropped; a query on a
// nonexistent group returns bin 0 with count 0.
module timing_offset_histogram_peak
    import tohp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hit_valid,
    output logic                hit_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [SERVER_W-1:0] server,
    input  logic [GROUP_W-1:0]  group,
    input  logic [CLOCK_W-1:0]  event_clock_low,
    input  logic [CLOCK_W-1:0]  chip_clock,
    output logic                peak_valid,
    input  logic                peak_stall,
    output logic [SERVER_W-1:0] out_server,
    output logic [GROUP_W-1:0]  out_group,
    output logic [BIN_W-1:0]    peak_bin,
    output logic [PEAK_W-1:0]   peak_count
);

    // queue handshake between front and back
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    q_stat_t qstat;
    logic    clearing;

    // classify items and drop those with no effect
    tohp_front u_front (
        .hit_valid       (hit_valid),
        .hit_stall       (hit_stall),
        .action          (action),
        .server          (server),
        .group           (group),
        .event_clock_low (event_clock_low),
        .chip_clock      (chip_clock),
        .qstat           (qstat),
        .clearing        (clearing),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    // decouple acceptance from the memory work
    tohp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // bin, scan, clear and deliver the peak
    tohp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .clearing   (clearing),
        .peak_valid (peak_valid),
        .peak_stall (peak_stall),
        .out_server (out_server),
        .out_group  (out_group),
        .peak_bin   (peak_bin),
        .peak_count (peak_count)
    );

endmodule

### tb/tb_timing_offset_histogram_peak.sv
// Self-checking testbench for timing_offset_histogram_peak: hits, peak queries, clears.
// Depends on tohp_pkg and the timing_offset_histogram_peak RTL. Holds its own histogram predictor.
`timescale 1ns / 100ps

module tb_timing_offset_histogram_peak
    import tohp_pkg::*;
();

    // Action code 3 has no name in the package; the block drops it.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS   = 1870;
    localparam int     CLEAR_SPACING  = 450;
    localparam int     HOLD_AT_ITEM   = 300;
    localparam int     RX_HOLD_CYCLES = 800;
    localparam int     DRAIN_CYCLES   = 700;
    localparam longint TIMEOUT_NS     = 20_000_000;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [SERVER_W-1:0] server;
        logic [GROUP_W-1:0]  group;
        logic [CLOCK_W-1:0]  ev_clk;
        logic [CLOCK_W-1:0]  chip_clk;
        bit                  wait_idle;  // hold this item back until no result is owed
        bit                  hold_rx;    // start the long output hold-off when taken
    } hit_item_t;

    typedef struct {
        logic [SERVER_W-1:0] server;
        logic [GROUP_W-1:0]  group;
        logic [BIN_W-1:0]    bin;
        logic [PEAK_W-1:0]   count;
    } peak_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                hit_valid = 1'b0;
    logic                hit_stall;
    logic [ACTION_W-1:0] action = ACT_HIT;
    logic [SERVER_W-1:0] server = '0;
    logic [GROUP_W-1:0]  group = '0;
    logic [CLOCK_W-1:0]  event_clock_low = '0;
    logic [CLOCK_W-1:0]  chip_clock = '0;
    logic                peak_valid;
    logic                peak_stall = 1'b0;
    logic [SERVER_W-1:0] out_server;
    logic [GROUP_W-1:0]  out_group;
    logic [BIN_W-1:0]    peak_bin;
    logic [PEAK_W-1:0]   peak_count;

    // Testbench state
    hit_item_t hit_items_q[$];        // items waiting to be offered
    peak_t     peak_expect_q[$];      // predicted query results, oldest first
    count_t    hist_model[DEPTH];     // predicted bin counters
    logic      hold_mark = 1'b0;      // the item on the port starts the hold-off
    int        hold_left = 0;
    int        owed = 0;              // registered copy of the expectation count
    int        taken_cnt = 0;
    int        total_items = 0;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        mismatch_cnt = 0;
    int        n_hits = 0;
    int        n_queries = 0;
    int        n_clears = 0;
    int        n_dropped = 0;
    int        n_checked = 0;
    int        n_in_stalls = 0;

    timing_offset_histogram_peak i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .hit_valid       (hit_valid),
        .hit_stall       (hit_stall),
        .action          (action),
        .server          (server),
        .group           (group),
        .event_clock_low (event_clock_low),
        .chip_clock      (chip_clock),
        .peak_valid      (peak_valid),
        .peak_stall      (peak_stall),
        .out_server      (out_server),
        .out_group       (out_group),
        .peak_bin        (peak_bin),
        .peak_count      (peak_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle mix per third of the run: sender light / receiver heavy, then swapped, then none.
    always_comb
    begin
        if (taken_cnt < total_items / 3)
        begin
            tx_idle_pct = 12;
            rx_idle_pct = 71;
        end
        else if (taken_cnt < (2 * total_items) / 3)
        begin
            tx_idle_pct = 71;
            rx_idle_pct = 12;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    function automatic void add_item(input logic [ACTION_W-1:0] act, input int srv,
                                     input int grp, input int ev, input int chip,
                                     input bit wait_idle = 1'b0, input bit hold_rx = 1'b0);
        hit_item_t it;
        it.action    = act;
        it.server    = SERVER_W'(srv);
        it.group     = GROUP_W'(grp);
        it.ev_clk    = CLOCK_W'(ev);
        it.chip_clk  = CLOCK_W'(chip);
        it.wait_idle = wait_idle;
        it.hold_rx   = hold_rx;
        hit_items_q.push_back(it);
    endfunction

    // Histogram predictor: apply one taken item to the model and queue any result it causes.
    task automatic tally_item(input logic [ACTION_W-1:0] act, input logic [SERVER_W-1:0] srv,
                              input logic [GROUP_W-1:0] grp, input logic [CLOCK_W-1:0] ev,
                              input logic [CLOCK_W-1:0] chip);
        bit               known;
        int               base;
        logic [BIN_W-1:0] offs;
        logic [BIN_W-1:0] best_bin;
        count_t           best;
        peak_t            res;
        known = (int'(srv) < NUM_SERVERS) && (int'(grp) < GROUPS_PER_SERVER);
        base  = (int'(srv) * GROUPS_PER_SERVER + int'(grp)) * HIST_BINS;
        case (act)
            ACT_HIT:
            begin
                if (known)
                begin
                    offs = ev - chip;   // 7-bit wrap gives the difference mod 128
                    if (hist_model[base + offs] != '1)
                        hist_model[base + offs] = hist_model[base + offs] + 1'b1;
                    n_hits++;
                end
                else
                    n_dropped++;
            end
            ACT_QUERY:
            begin
                best     = '0;
                best_bin = '0;
                // strict compare keeps the lowest bin on a tie
                if (known)
                    for (int b = 0; b < HIST_BINS; b++)
                        if (hist_model[base + b] > best)
                        begin
                            best     = hist_model[base + b];
                            best_bin = BIN_W'(b);
                        end
                res.server = srv;
                res.group  = grp;
                res.bin    = best_bin;
                res.count  = (64'(best) > 64'hFFFF_FFFF) ? '1 : PEAK_W'(best);
                peak_expect_q.push_back(res);
                n_queries++;
            end
            ACT_CLEAR:
            begin
                foreach (hist_model[i])
                    hist_model[i] = '0;
                n_clears++;
            end
            default:
                n_dropped++;
        endcase
    endtask

    // Driver: offer the next pending item once the current one has been taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        hit_item_t nxt;
        if (!rst_n)
        begin
            hit_valid <= 1'b0;
            hold_mark <= 1'b0;
        end
        else if (!hit_valid || !hit_stall)
        begin
            // A drain-first item waits for a cycle with nothing on the port and nothing owed.
            if (hit_items_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct &&
                !(hit_items_q[0].wait_idle && (hit_valid || owed != 0)))
            begin
                nxt = hit_items_q.pop_front();
                action          <= nxt.action;
                server          <= nxt.server;
                group           <= nxt.group;
                event_clock_low <= nxt.ev_clk;
                chip_clock      <= nxt.chip_clk;
                hold_mark       <= nxt.hold_rx;
                hit_valid       <= 1'b1;
            end
            else
                hit_valid <= 1'b0;
        end
    end

    // Long output hold-off, counted here, started by a marked item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hit_valid && !hit_stall && hold_mark)
            hold_left <= RX_HOLD_CYCLES;
    end

    // Receiver: stall at random, or solidly while the hold-off runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            peak_stall <= 1'b0;
        else
            peak_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Monitor: check taken results first, then feed the taken input item to the predictor.
    always @(posedge clk)
    begin : watch_ports
        peak_t got;
        peak_t want;
        if (rst_n)
        begin
            if (peak_valid && !peak_stall)
            begin
                got = '{out_server, out_group, peak_bin, peak_count};
                if (peak_expect_q.size() == 0)
                    report_mismatch($sformatf(
                        "result with nothing pending: srv %0d grp %0d bin %0d cnt %0d",
                        got.server, got.group, got.bin, got.count));
                else
                begin
                    want = peak_expect_q.pop_front();
                    if (got.server !== want.server)
                        report_mismatch($sformatf("out_server %0d, want %0d",
                                                  got.server, want.server));
                    if (got.group !== want.group)
                        report_mismatch($sformatf("out_group %0d, want %0d",
                                                  got.group, want.group));
                    if (got.bin !== want.bin)
                        report_mismatch($sformatf("peak_bin %0d, want %0d (srv %0d grp %0d)",
                                                  got.bin, want.bin, want.server, want.group));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("peak_count %0d, want %0d (srv %0d grp %0d)",
                                                  got.count, want.count, want.server,
                                                  want.group));
                    n_checked++;
                end
            end
            if (hit_valid && !hit_stall)
            begin
                tally_item(action, server, group, event_clock_low, chip_clock);
                taken_cnt <= taken_cnt + 1;
            end
            else if (hit_valid)
                n_in_stalls++;
            owed <= peak_expect_q.size();
        end
    end

    initial
    begin : run_test
        int srv;
        int grp;
        int pk;
        int n;
        int chip;
        int offs;
        int planned;
        int next_clear;
        bit hold_done;

        foreach (hist_model[i])
            hist_model[i] = '0;

        // Directed part: empty histograms, clock extremes and wrap, ties, bad groups,
        // the unused action code, and a clear with a query on each side.
        add_item(ACT_QUERY, 0, 0, 0, 0);
        add_item(ACT_QUERY, 7, 13, 127, 127);
        add_item(ACT_HIT, 0, 0, 0, 0);          // bin 0
        add_item(ACT_HIT, 0, 0, 0, 127);        // wraps to bin 1
        add_item(ACT_HIT, 0, 0, 127, 0);        // bin 127
        add_item(ACT_QUERY, 0, 0, 0, 0);        // three-way tie, lowest wins
        add_item(ACT_HIT, 0, 0, 127, 0);
        add_item(ACT_HIT, 0, 0, 1, 0);
        add_item(ACT_QUERY, 0, 0, 0, 0);        // bins 1 and 127 tie at two
        add_item(ACT_HIT, 7, 13, 127, 127);
        add_item(ACT_HIT, 7, 14, 5, 3);         // no such group: dropped
        add_item(ACT_HIT, 0, 15, 127, 0);       // no such group: dropped
        add_item(ACT_QUERY, 7, 14, 0, 0);       // echoes, bin 0 count 0
        add_item(ACT_QUERY, 3, 15, 0, 0);
        add_item(ACT_UNUSED, 5, 10, 42, 17);    // ignored
        add_item(ACT_QUERY, 7, 13, 0, 0);
        add_item(ACT_QUERY, 0, 0, 0, 0);        // still sees the pre-clear counts
        add_item(ACT_CLEAR, 2, 9, 85, 42);
        add_item(ACT_QUERY, 0, 0, 0, 0);
        add_item(ACT_HIT, 0, 0, 64, 0);
        add_item(ACT_QUERY, 0, 0, 0, 0);

        // Random part: mostly bursts of hits around one offset followed by a query of
        // that group, plus stray hits, stray queries and dropped codes.
        planned    = 0;
        next_clear = CLEAR_SPACING;
        hold_done  = 1'b0;
        while (planned < RANDOM_ITEMS)
        begin
            if (!hold_done && planned >= HOLD_AT_ITEM)
            begin
                // Stall the output for a long stretch while queries keep coming, so the
                // command queue fills up and hit_stall rises; then drain before going on.
                for (int i = 0; i < 12; i++)
                    add_item(ACT_QUERY, $urandom_range(0, 7), $urandom_range(0, 13), 0, 0,
                             1'b0, i == 0);
                add_item(ACT_QUERY, $urandom_range(0, 7), $urandom_range(0, 13), 0, 0, 1'b1);
                planned  += 13;
                hold_done = 1'b1;
            end
            else if (planned >= next_clear)
            begin
                add_item(ACT_CLEAR, $urandom_range(0, 7), $urandom_range(0, 15),
                         $urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
                next_clear += CLEAR_SPACING;
                planned++;
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 70)
                begin
                    srv = $urandom_range(0, 7);
                    grp = $urandom_range(0, 13);
                    pk  = $urandom_range(0, 127);
                    n   = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++)
                    begin
                        chip = $urandom_range(0, 127);
                        offs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : pk;
                        add_item(ACT_HIT, srv, grp, (chip + offs) % HIST_BINS, chip);
                    end
                    add_item(ACT_QUERY, srv, grp,
                             $urandom_range(0, 127), $urandom_range(0, 127));
                    planned += n + 1;
                end
                else if (n < 85)
                begin
                    grp = $urandom_range(0, 15);
                    add_item(ACT_HIT, $urandom_range(0, 7), grp,
                             $urandom_range(0, 127), $urandom_range(0, 127));
                    if (grp < GROUPS_PER_SERVER)
                        planned++;
                end
                else if (n < 95)
                begin
                    add_item(ACT_QUERY, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 127), $urandom_range(0, 127));
                    planned++;
                end
                else
                    add_item(ACT_UNUSED, $urandom_range(0, 7), $urandom_range(0, 15),
                             $urandom_range(0, 127), $urandom_range(0, 127));
            end
        end
        total_items = hit_items_q.size();

        // Reset once; the block then sweeps its memory with hit_stall high.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last item to be taken, then for every owed result.
        while (hit_items_q.size() != 0 || hit_valid)
            @(posedge clk);
        while (owed != 0 || peak_expect_q.size() != 0)
            @(posedge clk);
        // Let a trailing query or clear settle; nothing more may come out.
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (peak_expect_q.size() != 0)
        begin
            report_mismatch($sformatf("no result for query of srv %0d grp %0d",
                                      peak_expect_q[0].server, peak_expect_q[0].group));
            void'(peak_expect_q.pop_front());
        end

        $display("Covered %0d hits, %0d queries, %0d clears, %0d dropped items;",
                 n_hits, n_queries, n_clears, n_dropped);
        $display("%0d results checked, input held off on %0d cycles, one output hold-off of %0d.",
                 n_checked, n_in_stalls, RX_HOLD_CYCLES);
        if (mismatch_cnt == 0)
            $display("tb_timing_offset_histogram_peak OK");
        else
            $display("tb_timing_offset_histogram_peak NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (all queries, every sweep, every stall).
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout after %0d ns", TIMEOUT_NS);
        $display("tb_timing_offset_histogram_peak NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/tohp_pkg.sv
rtl/tohp_front.sv
rtl/tohp_fifo.sv
rtl/tohp_back.sv
rtl/timing_offset_histogram_peak.sv
tb/tb_timing_offset_histogram_peak.sv
